// File: rtl/soft_timer_bank_with_uptime_core_assert.svh
// Assertion macros shared by the checker of the soft timer bank.
// Each macro expands to one labeled concurrent assertion clocked by clk and reset by rst_n.
`ifndef SOFT_TIMER_BANK_WITH_UPTIME_CORE_ASSERT_SVH
`define SOFT_TIMER_BANK_WITH_UPTIME_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("soft timer bank check failed");

// Consequent must hold in the cycle after the antecedent.
`define STB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("soft timer bank check failed");

`endif

// File: rtl/stb_pkg.sv
// Package of the soft timer bank: sizes, command and operation codes, payload structs.
// Used by every module of the block; depends on nothing.
package stb_pkg;

    localparam int TIMER_SLOTS = 8;
    localparam int COUNT_BITS  = 32;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int ACT_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ACT_W-1:0]      LIVE_MAX    = ACT_W'(TIMER_SLOTS);
    localparam logic [SLOT_W-1:0]     LAST_SLOT   = SLOT_W'(TIMER_SLOTS - 1);
    localparam logic [30:0]           UPTIME_WRAP = 31'h7FFF_FFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_ZERO  = '0;

    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_CHECK   = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;
    localparam logic [2:0] CMD_ELAPSED = 3'd5;

    localparam logic [1:0] MODE_ONCE = 2'd0;
    localparam logic [1:0] MODE_AUTO = 2'd1;

    typedef enum logic [1:0] {
        RUN_STANDBY = 2'd0,
        RUN_ACTIVE  = 2'd1,
        RUN_STOPPED = 2'd2
    } run_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_START,
        OP_STOP,
        OP_CHECK,
        OP_TICK,
        OP_ELAPSED,
        OP_REJECT,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TICK,
        BK_FINISH
    } back_state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  slot;
        logic [1:0]  timer_mode;
        logic [31:0] preload;
        logic [30:0] last_time;
    } req_t;

    typedef struct packed {
        logic        expired;
        logic [30:0] elapsed_ms;
        logic        slot_error;
    } rsp_t;

    typedef struct packed {
        op_t                   op;
        logic [SLOT_W-1:0]     slot;
        logic [1:0]            timer_mode;
        logic [COUNT_BITS-1:0] preload;
        logic [30:0]           last_time;
    } entry_t;

endpackage

// File: rtl/stb_front.sv
// Front end of the soft timer bank: holds the active count and classifies each request.
// Depends on stb_pkg; feeds stb_queue.
module stb_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  stb_pkg::req_t             req_data,
    input  logic                      cfg_write_en,
    input  logic [stb_pkg::ACT_W-1:0] cfg_write_data,
    input  logic                      queue_full,
    output logic                      push,
    output stb_pkg::entry_t           entry,
    output logic [stb_pkg::ACT_W-1:0] live_count
);

    logic [stb_pkg::ACT_W-1:0] active_count_reg;
    logic [stb_pkg::ACT_W-1:0] active_count_next;
    logic                      slot_bad;

    always_comb
    begin
        active_count_next = cfg_write_en ? cfg_write_data : active_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= stb_pkg::LIVE_MAX;
        end
        else
        begin
            active_count_reg <= active_count_next;
        end
    end

    always_comb
    begin
        live_count = (active_count_reg > stb_pkg::LIVE_MAX) ? stb_pkg::LIVE_MAX
                                                             : active_count_reg;
        slot_bad   = ({1'b0, req_data.slot} >= live_count);
    end

    always_comb
    begin
        entry.slot       = req_data.slot;
        entry.timer_mode = req_data.timer_mode;
        entry.preload    = req_data.preload[stb_pkg::COUNT_BITS-1:0];
        entry.last_time  = req_data.last_time;
        unique case (req_data.command)
            stb_pkg::CMD_LOAD:    entry.op = slot_bad ? stb_pkg::OP_REJECT : stb_pkg::OP_LOAD;
            stb_pkg::CMD_START:   entry.op = slot_bad ? stb_pkg::OP_REJECT : stb_pkg::OP_START;
            stb_pkg::CMD_STOP:    entry.op = slot_bad ? stb_pkg::OP_REJECT : stb_pkg::OP_STOP;
            stb_pkg::CMD_CHECK:   entry.op = slot_bad ? stb_pkg::OP_REJECT : stb_pkg::OP_CHECK;
            stb_pkg::CMD_TICK:    entry.op = stb_pkg::OP_TICK;
            stb_pkg::CMD_ELAPSED: entry.op = stb_pkg::OP_ELAPSED;
            default:              entry.op = stb_pkg::OP_NONE;
        endcase
    end

    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full;

endmodule

// File: rtl/stb_queue.sv
// Short queue of classified requests between the front and back ends of the timer bank.
// Depends on stb_pkg for the entry type and depth.
module stb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stb_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output stb_pkg::entry_t head
);

    stb_pkg::entry_t               store_reg [stb_pkg::QUEUE_DEPTH];
    logic [stb_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [stb_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [stb_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [stb_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [stb_pkg::QPTR_W:0]      fill_reg;
    logic [stb_pkg::QPTR_W:0]      fill_next;

    localparam logic [stb_pkg::QPTR_W:0]   FILL_MAX = (stb_pkg::QPTR_W + 1)'(stb_pkg::QUEUE_DEPTH);
    localparam logic [stb_pkg::QPTR_W-1:0] PTR_LAST =
        stb_pkg::QPTR_W'(stb_pkg::QUEUE_DEPTH - 1);

    assign full      = (fill_reg == FILL_MAX);
    assign not_empty = (fill_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/stb_back.sv
// Back end of the soft timer bank: slot state, tick sequencer, uptime and the response register.
// Depends on stb_pkg; takes entries from stb_queue.
module stb_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  stb_pkg::entry_t           q_head,
    output logic                      pop,
    input  logic [stb_pkg::ACT_W-1:0] live_count,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output stb_pkg::rsp_t             rsp_data
);

    logic [stb_pkg::COUNT_BITS-1:0] count_reg  [stb_pkg::TIMER_SLOTS];
    logic [stb_pkg::COUNT_BITS-1:0] reload_reg [stb_pkg::TIMER_SLOTS];
    logic [1:0]                     mode_reg   [stb_pkg::TIMER_SLOTS];
    stb_pkg::run_t                  run_reg    [stb_pkg::TIMER_SLOTS];
    logic                           flag_reg   [stb_pkg::TIMER_SLOTS];
    logic [30:0]                    uptime_reg;
    logic [30:0]                    uptime_next;
    logic [stb_pkg::SLOT_W-1:0]     tick_k_reg;
    stb_pkg::back_state_t           state_reg;
    stb_pkg::back_state_t           state_next;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    stb_pkg::rsp_t                  rsp_data_reg;

    logic                           out_free;
    logic                           exec_single;
    logic                           tick_step;
    logic                           tick_finish;
    stb_pkg::rsp_t                  single_rsp;
    logic [31:0]                    diff;
    logic [stb_pkg::COUNT_BITS-1:0] tick_dec;
    logic                           tick_hit;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stb_pkg::BK_IDLE:
            begin
                if (q_valid && q_head.op == stb_pkg::OP_TICK)
                begin
                    state_next = stb_pkg::BK_TICK;
                end
            end
            stb_pkg::BK_TICK:
            begin
                if (tick_k_reg == stb_pkg::LAST_SLOT)
                begin
                    state_next = stb_pkg::BK_FINISH;
                end
            end
            stb_pkg::BK_FINISH:
            begin
                if (out_free)
                begin
                    state_next = stb_pkg::BK_IDLE;
                end
            end
            default: state_next = stb_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        exec_single = 1'b0;
        tick_step   = 1'b0;
        tick_finish = 1'b0;
        unique case (state_reg)
            stb_pkg::BK_IDLE:
            begin
                if (q_valid && q_head.op == stb_pkg::OP_TICK)
                begin
                    pop = 1'b1;
                end
                else if (q_valid && out_free)
                begin
                    pop         = 1'b1;
                    exec_single = 1'b1;
                end
            end
            stb_pkg::BK_TICK:   tick_step   = 1'b1;
            stb_pkg::BK_FINISH: tick_finish = out_free;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (uptime_reg >= q_head.last_time)
        begin
            diff = {1'b0, uptime_reg} - {1'b0, q_head.last_time};
        end
        else
        begin
            diff = {1'b0, stb_pkg::UPTIME_WRAP} - {1'b0, q_head.last_time} + {1'b0, uptime_reg};
        end
        single_rsp = '0;
        unique case (q_head.op)
            stb_pkg::OP_CHECK:   single_rsp.expired    = flag_reg[q_head.slot];
            stb_pkg::OP_ELAPSED: single_rsp.elapsed_ms = diff[30:0];
            stb_pkg::OP_REJECT:  single_rsp.slot_error = 1'b1;
            default:             single_rsp = '0;
        endcase
    end

    always_comb
    begin
        tick_dec = count_reg[tick_k_reg] - 1'b1;
        tick_hit = ({1'b0, tick_k_reg} < live_count)
                   && (run_reg[tick_k_reg] == stb_pkg::RUN_ACTIVE)
                   && (count_reg[tick_k_reg] != stb_pkg::COUNT_ZERO);
        uptime_next = (uptime_reg + 1'b1 == stb_pkg::UPTIME_WRAP) ? '0 : uptime_reg + 1'b1;
    end

    always_comb
    begin
        if (exec_single || tick_finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stb_pkg::BK_IDLE;
            tick_k_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            uptime_reg    <= '0;
            for (int i = 0; i < stb_pkg::TIMER_SLOTS; i++)
            begin
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
                mode_reg[i]   <= stb_pkg::MODE_ONCE;
                run_reg[i]    <= stb_pkg::RUN_STANDBY;
                flag_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (tick_step)
            begin
                tick_k_reg <= tick_k_reg + 1'b1;
            end
            else
            begin
                tick_k_reg <= '0;
            end
            if (tick_finish)
            begin
                uptime_reg <= uptime_next;
            end
            if (exec_single)
            begin
                unique case (q_head.op)
                    stb_pkg::OP_LOAD:
                    begin
                        mode_reg[q_head.slot]   <= q_head.timer_mode;
                        reload_reg[q_head.slot] <= q_head.preload;
                        count_reg[q_head.slot]  <= q_head.preload;
                        run_reg[q_head.slot]    <= stb_pkg::RUN_STANDBY;
                        flag_reg[q_head.slot]   <= 1'b0;
                    end
                    stb_pkg::OP_START:
                    begin
                        run_reg[q_head.slot] <= stb_pkg::RUN_ACTIVE;
                    end
                    stb_pkg::OP_STOP:
                    begin
                        run_reg[q_head.slot]    <= stb_pkg::RUN_STOPPED;
                        flag_reg[q_head.slot]   <= 1'b0;
                        mode_reg[q_head.slot]   <= stb_pkg::MODE_ONCE;
                        count_reg[q_head.slot]  <= '0;
                        reload_reg[q_head.slot] <= '0;
                    end
                    stb_pkg::OP_CHECK:
                    begin
                        flag_reg[q_head.slot] <= 1'b0;
                    end
                    default:
                    begin
                        flag_reg[q_head.slot] <= flag_reg[q_head.slot];
                    end
                endcase
            end
            if (tick_step && tick_hit)
            begin
                if (tick_dec != stb_pkg::COUNT_ZERO)
                begin
                    count_reg[tick_k_reg] <= tick_dec;
                end
                else
                begin
                    flag_reg[tick_k_reg] <= 1'b1;
                    if (mode_reg[tick_k_reg] == stb_pkg::MODE_AUTO)
                    begin
                        count_reg[tick_k_reg] <= reload_reg[tick_k_reg];
                    end
                    else
                    begin
                        count_reg[tick_k_reg] <= tick_dec;
                    end
                    if (mode_reg[tick_k_reg] == stb_pkg::MODE_ONCE)
                    begin
                        run_reg[tick_k_reg] <= stb_pkg::RUN_STANDBY;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_single)
        begin
            rsp_data_reg <= single_rsp;
        end
        else if (tick_finish)
        begin
            rsp_data_reg <= '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// File: rtl/soft_timer_bank_with_uptime_core.sv
// Top level of the soft timer bank with uptime counter.
// Depends on stb_pkg, stb_front, stb_queue and stb_back.
//
//   channel    handshake               payload
//   request    req_valid / req_stall   req_data (stb_pkg::req_t)
//   response   rsp_valid / rsp_stall   rsp_data (stb_pkg::rsp_t)
//   config     cfg_write_en            cfg_write_data (active count)
//
// Load, start, stop, check and elapsed each execute once the output register is free.
// Tick is popped, then steps through every slot, then answers and advances the uptime.
// A request reaches the back end through a two-entry queue; the front stalls when it is full.
// Reset is asynchronous: all slot state and uptime clear; the active count goes to TIMER_SLOTS.
// A stalled response holds in its output register while the queue goes on filling.
module soft_timer_bank_with_uptime_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  stb_pkg::req_t             req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output stb_pkg::rsp_t             rsp_data,
    input  logic                      cfg_write_en,
    input  logic [stb_pkg::ACT_W-1:0] cfg_write_data
);

    logic                      push;
    logic                      pop;
    logic                      queue_full;
    logic                      queue_not_empty;
    stb_pkg::entry_t           push_entry;
    stb_pkg::entry_t           head_entry;
    logic [stb_pkg::ACT_W-1:0] live_count;

    stb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .queue_full     (queue_full),
        .push           (push),
        .entry          (push_entry),
        .live_count     (live_count)
    );

    stb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head       (head_entry)
    );

    stb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (queue_not_empty),
        .q_head     (head_entry),
        .pop        (pop),
        .live_count (live_count),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

endmodule

// File: rtl/stb_checker.sv
// Port-level checker of the soft timer bank, attached to the top level by a bind.
// Depends on stb_pkg and the assertion macros in soft_timer_bank_with_uptime_core_assert.svh.
`include "soft_timer_bank_with_uptime_core_assert.svh"

module stb_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input stb_pkg::rsp_t rsp_data
);

    `STB_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)
    `STB_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data))
    `STB_ASSERT_NOW(a_err_excl, rsp_valid && rsp_data.slot_error, !rsp_data.expired)
    `STB_ASSERT_NOW(a_elapsed_excl, rsp_valid && rsp_data.elapsed_ms != 31'd0,
        !rsp_data.expired && !rsp_data.slot_error)

endmodule

bind soft_timer_bank_with_uptime_core stb_checker u_stb_checker (.*);
